>>> design/ldoc_pkg.sv
// ----------------------------------------------------------------------------
// ldoc_pkg: shared definitions for the light dimmer override controller
// Widths, register indexes, reset values, event codes and the duty scaler.
// ----------------------------------------------------------------------------
package ldoc_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int DUTY_BITS   = 16;
   localparam int AGE_BITS    = 16;
   localparam int PROD_BITS   = SAMPLE_BITS + DUTY_BITS;
   localparam int FOLDS       = (PROD_BITS + SAMPLE_BITS - 1) / SAMPLE_BITS + 1;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = (AGE_BITS > DUTY_BITS) ? AGE_BITS : DUTY_BITS;

   localparam logic [SAMPLE_BITS-1:0] SCALE_MAX      = {SAMPLE_BITS{1'b1}};
   localparam logic [AGE_BITS-1:0]    AGE_MAX        = {AGE_BITS{1'b1}};
   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(300);
   localparam logic [AGE_BITS-1:0]    TIMEOUT_RESET   = AGE_BITS'(30000);
   localparam logic [DUTY_BITS-1:0]   TOP_RESET       = DUTY_BITS'(255);
   localparam logic [DUTY_BITS-1:0]   ZERO_TOP_SCALE  = DUTY_BITS'(255);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_TIMEOUT   = 2'd1,
      CSR_TOP       = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_OVERRIDE = 3'd1,
      EV_AUTO     = 3'd2,
      EV_TIMEOUT  = 3'd3,
      EV_SLEPT    = 3'd4,
      EV_WOKE     = 3'd5
   } event_type;

   // Divide a product by 2^SAMPLE_BITS - 1 through repeated end-around folding:
   // x = s*2^S + r = s*(2^S-1) + (s + r).
   function automatic logic [DUTY_BITS-1:0] div_scale_max(input logic [PROD_BITS-1:0] x);
      logic [PROD_BITS:0] rest;
      logic [PROD_BITS:0] quot;
      logic [PROD_BITS:0] high;
      rest = {1'b0, x};
      quot = '0;
      for (int k = 0; k < FOLDS; k++) begin
         high = rest >> SAMPLE_BITS;
         quot = quot + high;
         rest = high + (PROD_BITS + 1)'(rest[SAMPLE_BITS-1:0]);
      end
      if (rest >= (PROD_BITS + 1)'(SCALE_MAX)) begin
         quot = quot + 1'b1;
      end
      return quot[DUTY_BITS-1:0];
   endfunction

endpackage

>>> design/ldoc_scale.sv
// ----------------------------------------------------------------------------
// ldoc_scale: duty scaler
// duty = sample * top / (2^SAMPLE_BITS - 1), rounded down; top of zero reads 255.
// ----------------------------------------------------------------------------
module ldoc_scale import ldoc_pkg::*; (
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [DUTY_BITS-1:0]   pwm_top,
   output logic [DUTY_BITS-1:0]   duty
);

   logic [DUTY_BITS-1:0] top;
   logic [PROD_BITS-1:0] product;

   always_comb begin
      top     = (pwm_top == '0) ? ZERO_TOP_SCALE : pwm_top;
      product = PROD_BITS'(sample) * PROD_BITS'(top);
      duty    = div_scale_max(product);
   end

endmodule

>>> design/light_dimmer_override_controller.sv
// ----------------------------------------------------------------------------
// light_dimmer_override_controller: dimmer with manual knob override
// A transferred request goes into the input register, then through one pass of
// control and duty scaling into the response register.
// Throughput: one item per cycle while the response side does not stall; the
// state update and the scaling multiply both finish in that single pass.
// Reset (synchronous, active high): registers back to defaults, awake,
// automatic mode, sample pending, knob reference not yet captured.
// ----------------------------------------------------------------------------
module light_dimmer_override_controller import ldoc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // config write port
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   // request stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,  // light_level[11:0], pot_level[23:12],
                                                 // ms_tick[24], sample_event[25],
                                                 // button_press[26], zero fill
   // response stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [23:0]               rsp_tdata   // duty[15:0], pwm_enabled[16],
                                                 // manual_active[17], event_code[20:18],
                                                 // zero fill
);

   localparam int IN_BITS  = 2 * SAMPLE_BITS + 3;
   localparam int OUT_BITS = DUTY_BITS + 5;

   // Configuration registers
   logic [SAMPLE_BITS-1:0] threshold_ff;
   logic [AGE_BITS-1:0]    timeout_ff;
   logic [DUTY_BITS-1:0]   top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         top_ff       <= TOP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_wdata[AGE_BITS-1:0];
            CSR_TOP:       top_ff       <= csr_wdata[DUTY_BITS-1:0];
            default:       ;
         endcase
      end
   end

   // Input register and response register handshake
   logic                 in_valid_ff;
   logic [IN_BITS-1:0]   in_data_ff;
   logic                 out_valid_ff;
   logic [OUT_BITS-1:0]  out_data_ff;
   logic                 advance;

   // Move the held item forward when the response slot is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(24 - OUT_BITS){1'b0}}, out_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata[IN_BITS-1:0];
      end
   end

   // Unpack the held item
   logic [SAMPLE_BITS-1:0] light;
   logic [SAMPLE_BITS-1:0] pot;
   logic                   tick;
   logic                   sample;
   logic                   press;

   assign light  = in_data_ff[SAMPLE_BITS-1:0];
   assign pot    = in_data_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign tick   = in_data_ff[2*SAMPLE_BITS];
   assign sample = in_data_ff[2*SAMPLE_BITS+1];
   assign press  = in_data_ff[2*SAMPLE_BITS+2];

   // Controller state
   logic                   system_on_ff,  system_on_in;
   logic                   manual_ff,     manual_in;
   logic                   pending_ff,    pending_in;
   logic [SAMPLE_BITS-1:0] knob_ref_ff,   knob_ref_in;
   logic                   primed_ff,     primed_in;
   logic [AGE_BITS-1:0]    age_ff,        age_in;
   logic [DUTY_BITS-1:0]   duty_hold_ff,  duty_hold_in;

   logic                   duty_update;
   logic [SAMPLE_BITS-1:0] scale_sample;
   logic [DUTY_BITS-1:0]   scaled_duty;
   logic [SAMPLE_BITS-1:0] knob_diff;
   event_type              event_code;

   ldoc_scale u_scale (
      .sample  (scale_sample),
      .pwm_top (top_ff),
      .duty    (scaled_duty)
   );

   // One poll step, in the fixed order (the first poll only primes the knob): age and sample
   // request, button, then knob override, override timeout and automatic update while awake.
   always_comb begin
      system_on_in = system_on_ff;
      manual_in    = manual_ff;
      pending_in   = pending_ff;
      knob_ref_in  = knob_ref_ff;
      primed_in    = primed_ff;
      age_in       = age_ff;
      duty_update  = 1'b0;
      scale_sample = light;
      event_code   = EV_NONE;
      knob_diff    = '0;

      if (!primed_ff) begin
         // first poll only captures the knob reference
         knob_ref_in = pot;
         primed_in   = 1'b1;
      end else begin
         if (tick && (age_ff != AGE_MAX)) begin
            age_in = age_ff + 1'b1;
         end
         if (sample) begin
            pending_in = 1'b1;
         end

         if (press) begin
            if (system_on_ff) begin
               system_on_in = 1'b0;
               event_code   = EV_SLEPT;
            end else begin
               system_on_in = 1'b1;
               manual_in    = 1'b0;
               pending_in   = 1'b1;
               knob_ref_in  = pot;
               event_code   = EV_WOKE;
            end
         end

         if (system_on_in) begin
            knob_diff = (pot >= knob_ref_in) ? pot - knob_ref_in : knob_ref_in - pot;
            if (knob_diff > threshold_ff) begin
               manual_in    = 1'b1;
               age_in       = '0;
               knob_ref_in  = pot;
               duty_update  = 1'b1;
               scale_sample = pot;
               event_code   = EV_OVERRIDE;
            end
            if (manual_in && (age_in >= timeout_ff)) begin
               manual_in   = 1'b0;
               pending_in  = 1'b1;
               knob_ref_in = pot;
               event_code  = EV_TIMEOUT;
            end
            if (!manual_in && pending_in) begin
               // automatic update wins the duty but reports only when quiet
               pending_in   = 1'b0;
               knob_ref_in  = pot;
               duty_update  = 1'b1;
               scale_sample = light;
               if (event_code == EV_NONE) begin
                  event_code = EV_AUTO;
               end
            end
         end
      end

      duty_hold_in = duty_update ? scaled_duty : duty_hold_ff;
   end

   // Commit state only when the item moves into the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         system_on_ff <= 1'b1;
         manual_ff    <= 1'b0;
         pending_ff   <= 1'b1;
         knob_ref_ff  <= '0;
         primed_ff    <= 1'b0;
         age_ff       <= '0;
         duty_hold_ff <= '0;
      end else if (advance) begin
         system_on_ff <= system_on_in;
         manual_ff    <= manual_in;
         pending_ff   <= pending_in;
         knob_ref_ff  <= knob_ref_in;
         primed_ff    <= primed_in;
         age_ff       <= age_in;
         duty_hold_ff <= duty_hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {event_code, manual_in, system_on_in, duty_hold_in};
      end
   end

endmodule

>>> dv/light_dimmer_override_controller_tb.sv
// ----------------------------------------------------------------------------
// light_dimmer_override_controller_tb: self-checking bench for the dimmer
// Drives poll items with random gaps and response stalls. A scoreboard class
// predicts duty, enable, manual state and event code per transfer and checks
// every response in order, across several register settings.
// ----------------------------------------------------------------------------
module light_dimmer_override_controller_tb import ldoc_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [DUTY_BITS-1:0] duty;
      logic                 awake;
      logic                 manual;
      event_type            code;
   } dimmer_status_type;

   // Scoreboard: own copy of the controller state, predicts one status per poll
   class dimmer_scoreboard;
      logic [SAMPLE_BITS-1:0] threshold;
      logic [AGE_BITS-1:0]    timeout;
      logic [DUTY_BITS-1:0]   top;
      logic                   awake;
      logic                   manual;
      logic                   pending;
      logic [SAMPLE_BITS-1:0] knob_ref;
      logic                   primed;
      logic [AGE_BITS-1:0]    age;
      logic [DUTY_BITS-1:0]   duty;
      dimmer_status_type      expected_status[$];
      int                     errors;
      int                     checked;

      function new();
         threshold = THRESHOLD_RESET;
         timeout   = TIMEOUT_RESET;
         top       = TOP_RESET;
         awake     = 1'b1;
         manual    = 1'b0;
         pending   = 1'b1;
         knob_ref  = '0;
         primed    = 1'b0;
         age       = '0;
         duty      = '0;
         errors    = 0;
         checked   = 0;
      endfunction

      function void set_register(csr_index_type index, logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_THRESHOLD: threshold = value[SAMPLE_BITS-1:0];
            CSR_TIMEOUT:   timeout   = value[AGE_BITS-1:0];
            CSR_TOP:       top       = value[DUTY_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [DUTY_BITS-1:0] scaled_duty(logic [SAMPLE_BITS-1:0] level);
         logic [63:0] scale;
         logic [63:0] product;
         scale   = (top == '0) ? 64'(ZERO_TOP_SCALE) : 64'(top);
         product = 64'(level) * scale;
         return DUTY_BITS'(product / 64'(SCALE_MAX));
      endfunction

      // Advance the state by one accepted poll and queue the status it yields
      function void note_poll(logic [31:0] data);
         logic [SAMPLE_BITS-1:0] light;
         logic [SAMPLE_BITS-1:0] pot;
         logic [SAMPLE_BITS-1:0] diff;
         logic                   tick;
         logic                   sample;
         logic                   press;
         event_type              code;
         dimmer_status_type      status;
         light  = data[11:0];
         pot    = data[23:12];
         tick   = data[24];
         sample = data[25];
         press  = data[26];
         code   = EV_NONE;
         if (!primed) begin
            knob_ref = pot;
            primed   = 1'b1;
         end else begin
            if (tick && age != AGE_MAX) age = age + 1'b1;
            if (sample) pending = 1'b1;
            if (press) begin
               if (awake) begin
                  awake = 1'b0;
                  code  = EV_SLEPT;
               end else begin
                  awake    = 1'b1;
                  manual   = 1'b0;
                  pending  = 1'b1;
                  knob_ref = pot;
                  code     = EV_WOKE;
               end
            end
            if (awake) begin
               diff = (pot >= knob_ref) ? pot - knob_ref : knob_ref - pot;
               if (diff > threshold) begin
                  manual   = 1'b1;
                  age      = '0;
                  knob_ref = pot;
                  duty     = scaled_duty(pot);
                  code     = EV_OVERRIDE;
               end
               if (manual && age >= timeout) begin
                  manual   = 1'b0;
                  pending  = 1'b1;
                  knob_ref = pot;
                  code     = EV_TIMEOUT;
               end
               if (!manual && pending) begin
                  pending  = 1'b0;
                  duty     = scaled_duty(light);
                  knob_ref = pot;
                  if (code == EV_NONE) code = EV_AUTO;
               end
            end
         end
         status.duty   = duty;
         status.awake  = awake;
         status.manual = manual;
         status.code   = code;
         expected_status.push_back(status);
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, what);
      endtask

      task check_status(logic [23:0] data);
         dimmer_status_type want;
         checked++;
         if (expected_status.size() == 0) begin
            report($sformatf("response %h with no poll outstanding", data));
         end else begin
            want = expected_status.pop_front();
            if (data[15:0] !== want.duty)
               report($sformatf("duty %0d, expected %0d", data[15:0], want.duty));
            if (data[16] !== want.awake)
               report($sformatf("pwm_enabled %b, expected %b", data[16], want.awake));
            if (data[17] !== want.manual)
               report($sformatf("manual_active %b, expected %b", data[17], want.manual));
            if (data[20:18] !== want.code)
               report($sformatf("event_code %0d, expected %0d", data[20:18], want.code));
            if (data[23:21] !== 3'b000)
               report($sformatf("fill bits %b not zero", data[23:21]));
         end
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [31:0]               req_tdata;   // light_level[11:0], pot_level[23:12], ms_tick[24],
                                           // sample_event[25], button_press[26], zero fill
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [23:0]               rsp_tdata;   // duty[15:0], pwm_enabled[16], manual_active[17],
                                           // event_code[20:18], zero fill

   dimmer_scoreboard sb = new();
   int               cycle_count = 0;
   bit               burst = 1'b0;   // no sender gaps while set

   light_dimmer_override_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [31:0] pack_poll(logic [11:0] light, logic [11:0] pot,
                                             logic tick, logic sample, logic press);
      return {5'b0, press, sample, tick, pot, light};
   endfunction

   // Offer one poll, hold it until the transfer, then note it and idle for a random gap, maybe none
   task automatic send_poll(logic [31:0] data);
      int r;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_poll(data);
      r = $urandom_range(99);
      if (burst || r < 55) gap = 0;
      else if (r < 92)     gap = $urandom_range(1, 3);
      else                 gap = $urandom_range(8, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted status has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_registers(logic [15:0] threshold, logic [15:0] timeout,
                                  logic [15:0] top);
      csr_we    <= 1'b1;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= threshold;
      @(posedge clock);
      sb.set_register(CSR_THRESHOLD, threshold);
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      sb.set_register(CSR_TIMEOUT, timeout);
      csr_index <= CSR_TOP;
      csr_wdata <= top;
      @(posedge clock);
      sb.set_register(CSR_TOP, top);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Build one random poll. The knob mostly jitters near its reference, sometimes
   // lands right at the threshold edge, sometimes jumps anywhere.
   task automatic random_poll(int tick_pct, output logic [31:0] data);
      int r;
      int pot;
      int step;
      r = $urandom_range(99);
      if (r < 15) begin
         pot = $urandom_range(4095);
      end else if (r < 30) begin
         step = int'(sb.threshold) + int'($urandom_range(1));
         pot  = int'(sb.knob_ref) + step;
         if (pot > 4095) pot = int'(sb.knob_ref) - step;
         if (pot < 0) pot = $urandom_range(4095);
      end else begin
         pot = int'(sb.knob_ref) + int'($urandom_range(30)) - 15;
         if (pot < 0) pot = 0;
         if (pot > 4095) pot = 4095;
      end
      data = pack_poll(12'($urandom_range(4095)), pot[11:0],
                       $urandom_range(99) < tick_pct,
                       $urandom_range(99) < 25,
                       $urandom_range(99) < 3);
   endtask

   // Response side: random stalls, calm stretches, and one long hold-off that
   // lets the pipeline back up into the request side
   initial begin : response_sink
      int  stall_left;
      int  r;
      bit  hold_done;
      bit  steady;
      stall_left = 0;
      hold_done  = 1'b0;
      steady     = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
         if (!hold_done && sb.checked >= 500) begin
            hold_done  = 1'b1;
            stall_left = 300;
         end
         if ($urandom_range(199) == 0) steady = !steady;
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady) begin
               r = $urandom_range(99);
               if (r < 25)      stall_left = $urandom_range(1, 3);
               else if (r < 28) stall_left = $urandom_range(10, 40);
            end
         end
      end
   end

   initial begin : stimulus
      logic [31:0] item;
      logic [15:0] threshold;
      logic [15:0] timeout;
      logic [15:0] top;
      int          tick_pct;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= CSR_THRESHOLD;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: priming, auto updates, threshold edge, sleep and wake
      send_poll(pack_poll(12'd4095, 12'd2000, 1'b1, 1'b1, 1'b1)); // only primes the knob
      send_poll(pack_poll(12'd4095, 12'd2000, 1'b0, 1'b0, 1'b0)); // pending from reset
      send_poll(pack_poll(12'd0,    12'd2000, 1'b0, 1'b1, 1'b0));
      send_poll(pack_poll(12'd123,  12'd2300, 1'b0, 1'b0, 1'b0)); // move equal to threshold
      send_poll(pack_poll(12'd0,    12'd2301, 1'b0, 1'b0, 1'b0)); // one past: override
      send_poll(pack_poll(12'd0,    12'd4095, 1'b0, 1'b0, 1'b0));
      send_poll(pack_poll(12'd0,    12'd0,    1'b1, 1'b0, 1'b0));
      send_poll(pack_poll(12'd0,    12'd4095, 1'b0, 1'b1, 1'b1)); // sleep
      send_poll(pack_poll(12'd0,    12'd1000, 1'b1, 1'b1, 1'b0)); // sample while asleep
      send_poll(pack_poll(12'd2048, 12'd1000, 1'b0, 1'b0, 1'b1)); // wake
      send_poll(pack_poll(12'd4095, 12'd1000, 1'b0, 1'b1, 1'b0));
      send_poll(pack_poll(12'd777,  12'd1000, 1'b0, 1'b1, 1'b1)); // sleep
      send_poll(pack_poll(12'd4095, 12'd4095, 1'b0, 1'b0, 1'b1)); // wake
      drain();

      // Zero threshold, zero timeout, zero top: override ends in the same poll
      write_registers(16'd0, 16'd0, 16'd0);
      send_poll(pack_poll(12'd100,  12'd4094, 1'b0, 1'b0, 1'b0));
      send_poll(pack_poll(12'd100,  12'd4094, 1'b0, 1'b0, 1'b0));
      send_poll(pack_poll(12'd4095, 12'd0,    1'b1, 1'b0, 1'b0));
      drain();

      // Widest scale, threshold that no move exceeds
      write_registers(16'd4095, 16'd2, 16'd65535);
      send_poll(pack_poll(12'd4095, 12'd4095, 1'b0, 1'b1, 1'b0));
      send_poll(pack_poll(12'd1,    12'd0,    1'b0, 1'b1, 1'b0));
      drain();

      // Override, then two ticks run it into the timeout
      write_registers(16'd10, 16'd2, 16'd65535);
      send_poll(pack_poll(12'd500,  12'd3000, 1'b0, 1'b0, 1'b0));
      send_poll(pack_poll(12'd500,  12'd3000, 1'b1, 1'b0, 1'b0));
      send_poll(pack_poll(12'd900,  12'd3000, 1'b1, 1'b0, 1'b0));
      send_poll(pack_poll(12'd900,  12'd3000, 1'b0, 1'b0, 1'b1));
      send_poll(pack_poll(12'd3333, 12'd100,  1'b1, 1'b0, 1'b1));
      drain();

      // Random phases, one register setting each
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               threshold = 16'd0;     timeout = 16'd1;     top = 16'd65535; tick_pct = 60;
            end
            1: begin
               threshold = 16'd4095;  timeout = 16'd65535; top = 16'd0;     tick_pct = 50;
            end
            2: begin
               threshold = 16'($urandom_range(65535));
               timeout   = 16'd0;
               top       = 16'($urandom_range(65535));
               tick_pct  = 50;
            end
            3: begin
               threshold = 16'($urandom_range(20, 400));
               timeout   = 16'($urandom_range(1, 30));
               top       = 16'($urandom_range(65535));
               tick_pct  = 70;
            end
            4: begin
               threshold = 16'($urandom_range(100));
               timeout   = 16'($urandom_range(2, 12));
               top       = 16'd255;
               tick_pct  = 40;
            end
            default: begin
               threshold = 16'd300;   timeout = 16'd30000;
               top       = 16'($urandom_range(65535));
               tick_pct  = 50;
            end
         endcase
         write_registers(threshold, timeout, top);
         for (int n = 0; n < 265; n++) begin
            if (n % 64 == 0) burst = ($urandom_range(3) == 0);
            random_poll(tick_pct, item);
            send_poll(item);
         end
         burst = 1'b0;
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
